### hdl/wcs_pkg.sv
// Package for the wheel command shaper with watchdog.
// Holds register defaults, register indexes, send cause codes and shared structs.
// No dependencies.
package wcs_pkg;

  // Default values of module parameters.
  localparam int TIME_BITS_DEFAULT      = 48;
  localparam int CHANGE_EPSILON_DEFAULT = 5;

  // Register widths.
  localparam int SPEED_BITS = 16;
  localparam int LIMIT_BITS = 15;
  localparam int TRIM_BITS  = 16;
  localparam int US_BITS    = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Register reset values.
  localparam logic [LIMIT_BITS-1:0] DEADBAND_RESET        = 15'd358;
  localparam logic [LIMIT_BITS-1:0] MAX_SPEED_RESET       = 15'd10240;
  localparam logic [TRIM_BITS-1:0]  TRIM_FACTOR_RESET     = 16'd16384;
  localparam logic [US_BITS-1:0]    STOP_TIMEOUT_US_RESET = 32'd500000;
  localparam logic [US_BITS-1:0]    SEND_PERIOD_US_RESET  = 32'd50000;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SPEED       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM_FACTOR     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_TIMEOUT_US = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEND_PERIOD_US  = 3'd4;

  // Reason attached to each result word.
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_NORMAL   = 2'd1,
    CAUSE_SNAP     = 2'd2,
    CAUSE_WATCHDOG = 2'd3
  } cause_t;

  // Current register contents.
  typedef struct packed {
    logic [LIMIT_BITS-1:0] deadband;
    logic [LIMIT_BITS-1:0] max_speed;
    logic [TRIM_BITS-1:0]  trim_factor;
    logic [US_BITS-1:0]    stop_timeout_us;
    logic [US_BITS-1:0]    send_period_us;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic                         send_valid;
    logic signed [SPEED_BITS-1:0] left_out;
    logic signed [SPEED_BITS-1:0] right_out;
    cause_t                       send_cause;
  } result_t;

endpackage

### hdl/wcs_cfg_regs.sv
// Configuration register file for the wheel command shaper.
// Decodes writes from the configuration channel into the cfg_t struct.
// Depends on wcs_pkg.
module wcs_cfg_regs
  import wcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband        <= DEADBAND_RESET;
      cfg.max_speed       <= MAX_SPEED_RESET;
      cfg.trim_factor     <= TRIM_FACTOR_RESET;
      cfg.stop_timeout_us <= STOP_TIMEOUT_US_RESET;
      cfg.send_period_us  <= SEND_PERIOD_US_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEADBAND:        cfg.deadband        <= cfg_data[LIMIT_BITS-1:0];
        CFG_MAX_SPEED:       cfg.max_speed       <= cfg_data[LIMIT_BITS-1:0];
        CFG_TRIM_FACTOR:     cfg.trim_factor     <= cfg_data[TRIM_BITS-1:0];
        CFG_STOP_TIMEOUT_US: cfg.stop_timeout_us <= cfg_data[US_BITS-1:0];
        CFG_SEND_PERIOD_US:  cfg.send_period_us  <= cfg_data[US_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/wcs_shaper.sv
// Per-wheel deadband and clamp, then left-wheel trim when both wheels turn the same way.
// Pure combinational logic between the input register and the decision stage.
// Depends on wcs_pkg.
module wcs_shaper
  import wcs_pkg::*;
(
  input  cfg_t                         cfg,
  input  logic signed [SPEED_BITS-1:0] left_request,
  input  logic signed [SPEED_BITS-1:0] right_request,
  output logic signed [SPEED_BITS-1:0] left_shaped,
  output logic signed [SPEED_BITS-1:0] right_shaped
);

  // Snap small magnitudes to zero, then clamp to the speed limit.
  function automatic logic signed [SPEED_BITS-1:0] shape_wheel(
    input logic signed [SPEED_BITS-1:0] v,
    input logic [LIMIT_BITS-1:0]        thr,
    input logic [LIMIT_BITS-1:0]        lim
  );
    logic [SPEED_BITS-1:0] mag;
    logic [SPEED_BITS-1:0] lim_w;
    mag   = v[SPEED_BITS-1] ? SPEED_BITS'(-v) : SPEED_BITS'(v);
    lim_w = {1'b0, lim};
    if (mag < {1'b0, thr}) begin
      return '0;
    end else if (mag > lim_w) begin
      return v[SPEED_BITS-1] ? signed'(SPEED_BITS'(-lim_w)) : signed'(lim_w);
    end else begin
      return v;
    end
  endfunction

  logic signed [SPEED_BITS-1:0] l_base;
  logic [LIMIT_BITS-1:0]        l_mag;
  logic [LIMIT_BITS+TRIM_BITS-1:0] prod;
  logic [LIMIT_BITS+1:0]        q_mag;
  logic [LIMIT_BITS-1:0]        q_clamp;
  logic                         same_dir;

  assign l_base       = shape_wheel(left_request, cfg.deadband, cfg.max_speed);
  assign right_shaped = shape_wheel(right_request, cfg.deadband, cfg.max_speed);

  // After clamping the left magnitude fits in the limit width.
  assign l_mag = l_base[SPEED_BITS-1] ? LIMIT_BITS'(-l_base) : l_base[LIMIT_BITS-1:0];

  // Trim works on the magnitude so the shift truncates toward zero.
  assign prod    = l_mag * cfg.trim_factor;
  assign q_mag   = prod[LIMIT_BITS+TRIM_BITS-1:TRIM_BITS-2];
  assign q_clamp = (q_mag > {2'b00, cfg.max_speed}) ? cfg.max_speed : q_mag[LIMIT_BITS-1:0];

  assign same_dir = ((l_base > 0) && (right_shaped > 0)) ||
                    (l_base[SPEED_BITS-1] && right_shaped[SPEED_BITS-1]);

  always_comb begin
    if (same_dir) begin
      left_shaped = l_base[SPEED_BITS-1] ? signed'(SPEED_BITS'(-{1'b0, q_clamp}))
                                         : signed'({1'b0, q_clamp});
    end else begin
      left_shaped = l_base;
    end
  end

endmodule

### hdl/wcs_decide.sv
// Send decision: watchdog stop, snap stop, rate or change driven send, or nothing.
// Holds the last sent pair, timestamps and flags, and the result register.
// Depends on wcs_pkg.
module wcs_decide
  import wcs_pkg::*;
#(
  parameter int TIME_BITS      = TIME_BITS_DEFAULT,
  parameter int CHANGE_EPSILON = CHANGE_EPSILON_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TIME_BITS-1:0]         now_us,
  input  logic signed [SPEED_BITS-1:0] left_shaped,
  input  logic signed [SPEED_BITS-1:0] right_shaped,
  output logic                         out_valid,
  input  logic                         out_ready,
  output result_t                      result
);

  localparam int DIFF_BITS = SPEED_BITS + 1;

  // State carried from item to item.
  logic signed [SPEED_BITS-1:0] last_left_sent;
  logic signed [SPEED_BITS-1:0] last_right_sent;
  logic [TIME_BITS-1:0]         last_send_time;
  logic                         sent_ever;
  logic [TIME_BITS-1:0]         last_moving_time;
  logic                         moving_seen;
  logic                         watchdog_fired;

  logic                 advance;
  logic                 moving;
  logic                 last_nonzero;
  logic [TIME_BITS-1:0] idle_time;
  logic [TIME_BITS-1:0] since_send;
  logic                 wd_fire;
  logic                 time_ok;
  logic                 changed;
  logic signed [DIFF_BITS-1:0] diff_l;
  logic signed [DIFF_BITS-1:0] diff_r;
  logic [DIFF_BITS-1:0] adiff_l;
  logic [DIFF_BITS-1:0] adiff_r;
  result_t              result_next;

  // The result register frees up when empty or when its word is taken.
  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  // Elapsed times wrap at the time width.
  assign moving       = (left_shaped != 0) || (right_shaped != 0);
  assign last_nonzero = (last_left_sent != 0) || (last_right_sent != 0);
  assign idle_time    = now_us - last_moving_time;
  assign since_send   = now_us - last_send_time;
  assign wd_fire      = !moving && moving_seen && !watchdog_fired &&
                        (idle_time > TIME_BITS'(cfg.stop_timeout_us));
  assign time_ok      = !sent_ever || (since_send >= TIME_BITS'(cfg.send_period_us));

  // Change test against the last sent pair.
  assign diff_l  = DIFF_BITS'(left_shaped) - DIFF_BITS'(last_left_sent);
  assign diff_r  = DIFF_BITS'(right_shaped) - DIFF_BITS'(last_right_sent);
  assign adiff_l = diff_l[DIFF_BITS-1] ? DIFF_BITS'(-diff_l) : DIFF_BITS'(diff_l);
  assign adiff_r = diff_r[DIFF_BITS-1] ? DIFF_BITS'(-diff_r) : DIFF_BITS'(diff_r);
  assign changed = (adiff_l > DIFF_BITS'(CHANGE_EPSILON)) ||
                   (adiff_r > DIFF_BITS'(CHANGE_EPSILON));

  // Pick the result word in priority order.
  always_comb begin
    result_next = '{send_valid: 1'b0, left_out: '0, right_out: '0, send_cause: CAUSE_NONE};
    priority if (wd_fire) begin
      result_next.send_valid = 1'b1;
      result_next.send_cause = CAUSE_WATCHDOG;
    end else if (!moving) begin
      if (last_nonzero) begin
        result_next.send_valid = 1'b1;
        result_next.send_cause = CAUSE_SNAP;
      end
    end else if (time_ok || changed) begin
      result_next.send_valid = 1'b1;
      result_next.left_out   = left_shaped;
      result_next.right_out  = right_shaped;
      result_next.send_cause = CAUSE_NORMAL;
    end else begin
      // Unchanged command inside the resend period: nothing is sent.
      result_next.send_cause = CAUSE_NONE;
    end
  end

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      last_left_sent   <= '0;
      last_right_sent  <= '0;
      last_send_time   <= '0;
      sent_ever        <= 1'b0;
      last_moving_time <= '0;
      moving_seen      <= 1'b0;
      watchdog_fired   <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (moving) begin
          last_moving_time <= now_us;
          moving_seen      <= 1'b1;
          watchdog_fired   <= 1'b0;
        end else if (wd_fire) begin
          watchdog_fired <= 1'b1;
        end
        if (result_next.send_valid) begin
          last_left_sent  <= result_next.left_out;
          last_right_sent <= result_next.right_out;
          last_send_time  <= now_us;
          sent_ever       <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A word is a send exactly when it carries a cause.
  a_valid_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.send_valid == (result.send_cause != CAUSE_NONE)))
    else $error("send flag and cause disagree");

  // Stops and idle words carry zero speeds.
  a_stop_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.send_cause != CAUSE_NORMAL) |->
      (result.left_out == 0) && (result.right_out == 0))
    else $error("stop or idle word with nonzero speed");

  // A watchdog stop arms the latch and is remembered as the last send.
  a_watchdog_latch: assert property (@(posedge clk) disable iff (rst)
    advance && wd_fire |=> watchdog_fired && sent_ever && !last_nonzero)
    else $error("watchdog stop not recorded");

  // Motion clears the watchdog and records the time.
  a_motion_rearms: assert property (@(posedge clk) disable iff (rst)
    advance && moving |=> moving_seen && !watchdog_fired &&
      (last_moving_time == $past(now_us)))
    else $error("motion did not rearm the watchdog");

endmodule

### hdl/wheel_command_shaper_watchdog.sv
// Wheel command shaper with watchdog, top level.
// Each input word goes through the input register, then the result register.
// Throughput: one word per cycle unless m_tready stalls the result register.
// Reset (synchronous, active high) loads defaults, clears flags and decision state.
// Depends on wcs_pkg, wcs_cfg_regs, wcs_shaper and wcs_decide.
module wheel_command_shaper_watchdog
  import wcs_pkg::*;
#(
  parameter int TIME_BITS      = TIME_BITS_DEFAULT,
  parameter int CHANGE_EPSILON = CHANGE_EPSILON_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // Input words
  input  logic s_tvalid,
  output logic s_tready,
  // now_us [TIME_BITS-1:0], left_request, right_request, zero fill to bytes
  input  logic [((TIME_BITS + 2*SPEED_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // Result words
  output logic m_tvalid,
  input  logic m_tready,
  // send_valid, left_out, right_out, zero fill to bytes
  output logic [((1 + 2*SPEED_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  // send_cause
  output logic [1:0] m_tuser,
  // Configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int M_DATA_BITS = ((1 + 2*SPEED_BITS + 7) / 8) * 8;

  cfg_t cfg;

  // Input register.
  logic                         in_valid;
  logic [TIME_BITS-1:0]         in_now;
  logic signed [SPEED_BITS-1:0] in_left;
  logic signed [SPEED_BITS-1:0] in_right;
  logic                         stage_ready;

  logic signed [SPEED_BITS-1:0] left_shaped;
  logic signed [SPEED_BITS-1:0] right_shaped;
  result_t                      result;

  wcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The input register refills whenever its word moves on.
  assign s_tready = !in_valid || stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now   <= s_tdata[TIME_BITS-1:0];
      in_left  <= s_tdata[TIME_BITS +: SPEED_BITS];
      in_right <= s_tdata[TIME_BITS+SPEED_BITS +: SPEED_BITS];
    end
  end

  wcs_shaper u_shaper (
    .cfg           (cfg),
    .left_request  (in_left),
    .right_request (in_right),
    .left_shaped   (left_shaped),
    .right_shaped  (right_shaped)
  );

  wcs_decide #(
    .TIME_BITS      (TIME_BITS),
    .CHANGE_EPSILON (CHANGE_EPSILON)
  ) u_decide (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (stage_ready),
    .now_us       (in_now),
    .left_shaped  (left_shaped),
    .right_shaped (right_shaped),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .result       (result)
  );

  // Result packing.
  assign m_tdata = M_DATA_BITS'({result.right_out, result.left_out, result.send_valid});
  assign m_tuser = result.send_cause;

endmodule
